>>> sv/vags_pkg.sv
// Shared constants for the Van Albada gradient stream core.
// No dependencies.
package vags_pkg;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int NUM_W     = 96;
  localparam int DEN_W     = 64;
  localparam int QBITS     = 32;
  localparam int CNT_W     = $clog2(QBITS);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_GRAD  = 4'd1;
  localparam logic [3:0] ST_PRE   = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_END   = 4'd4;
  localparam logic [3:0] ST_LIM   = 4'd5;
  localparam logic [3:0] ST_M1    = 4'd6;
  localparam logic [3:0] ST_M2    = 4'd7;
  localparam logic [3:0] ST_M3    = 4'd8;
  localparam logic [3:0] ST_M4    = 4'd9;
  localparam logic [3:0] ST_M5    = 4'd10;
  localparam logic [3:0] ST_EMIT1 = 4'd11;
  localparam logic [3:0] ST_EMIT2 = 4'd12;

  localparam logic MODE_GRAD  = 1'b0;
  localparam logic MODE_LIMIT = 1'b1;
endpackage

>>> sv/van_albada_gradient_stream_core.sv
// Van Albada slope limiter over a stream of (value, position) samples.
// Depends on vags_pkg.
//
// One request is taken at a time; s_tready is low while it is worked on. A
// sample's slope is sent when the next sample arrives, and a final sample that
// follows another sends two results. Each gradient of a valid step and each limited
// slope that is not trivially zero passes through one shared radix-2 divider (a
// range check, the quotient bits, then a result step); the limited slope first
// passes the multiply states M1 to M5 on one shared 32x33 multiplier. A sample
// that follows another keeps s_tready low until its slope is sent (shorter when a
// step faults, a quotient overflows or the slope is trivially zero), and a final
// sample also for its second result. A first sample that is not final leaves it high.
module van_albada_gradient_stream_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // sample_value[31:0], sample_position[63:32]
  input  logic        s_tlast,   // is_final
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // slope[31:0]
  output logic        m_tuser,   // step_fault
  output logic        m_tlast    // run_end
);
  import vags_pkg::*;

  logic [3:0]              state;
  logic                    mode;
  logic signed [DATA_W-1:0] in_v, in_x, held_value, held_position;
  logic signed [DATA_W-1:0] held_left_gradient, g;
  logic                    in_fin, held_fault, sample_pending, lf;
  logic [NUM_W-1:0]        num;
  logic [DEN_W-1:0]        den, r, ab;
  logic [QBITS-1:0]        numlo, q;
  logic [CNT_W-1:0]        cnt;
  logic                    ovf, neg;
  logic [DATA_W-1:0]       res;

  logic signed [DATA_W:0]  dv, dx, sum;
  logic [DATA_W:0]         dv_mag, s_mag;
  logic [DATA_W-1:0]       a_mag, b_mag;
  logic [DEN_W:0]          r2;
  logic [DATA_W-1:0]       mx;
  logic [DATA_W:0]         my;
  logic [DATA_W*2:0]       prod;
  logic [DATA_W-1:0]       sat_res;

  assign dv = {in_v[DATA_W-1], in_v} - {held_value[DATA_W-1], held_value};
  assign dx = {in_x[DATA_W-1], in_x} - {held_position[DATA_W-1], held_position};
  assign dv_mag = dv[DATA_W] ? (DATA_W+1)'(0) - dv : dv;
  assign sum = {held_left_gradient[DATA_W-1], held_left_gradient} + {g[DATA_W-1], g};
  assign s_mag = sum[DATA_W] ? (DATA_W+1)'(0) - sum : sum;
  assign a_mag = held_left_gradient[DATA_W-1] ? DATA_W'(0) - held_left_gradient
                                              : held_left_gradient;
  assign b_mag = g[DATA_W-1] ? DATA_W'(0) - g : g;
  assign r2 = {r, numlo[QBITS-1]};

  always_comb begin
    mx = a_mag;
    my = {1'b0, a_mag};
    case (state)
      ST_M1:   begin mx = a_mag;            my = {1'b0, a_mag}; end
      ST_M2:   begin mx = b_mag;            my = {1'b0, b_mag}; end
      ST_M3:   begin mx = a_mag;            my = {1'b0, b_mag}; end
      ST_M4:   begin mx = ab[31:0];         my = s_mag;         end
      ST_M5:   begin mx = ab[63:32];        my = s_mag;         end
      default: begin mx = a_mag;            my = {1'b0, a_mag}; end
    endcase
    prod = (DATA_W*2+1)'(mx) * (DATA_W*2+1)'(my);
  end

  always_comb begin
    if (neg) begin
      if (ovf || q > 32'h8000_0000) sat_res = 32'h8000_0000;
      else sat_res = 32'd0 - q;
    end else begin
      if (ovf || q[QBITS-1]) sat_res = 32'h7FFF_FFFF;
      else sat_res = q;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      sample_pending <= 1'b0;
      held_value <= '0;
      held_position <= '0;
      held_left_gradient <= '0;
      held_fault <= 1'b0;
      lf <= 1'b0;
      mode <= MODE_GRAD;
    end else begin
      if (m_tvalid && m_tready && state != ST_EMIT1 && state != ST_EMIT2)
        m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            in_v <= s_tdata[31:0];
            in_x <= s_tdata[63:32];
            in_fin <= s_tlast;
            lf <= 1'b0;
            if (sample_pending) state <= ST_GRAD;
            else if (s_tlast) state <= ST_EMIT2;
            else begin
              held_value <= s_tdata[31:0];
              held_position <= s_tdata[63:32];
              held_left_gradient <= '0;
              held_fault <= 1'b0;
              sample_pending <= 1'b1;
            end
          end
        end
        ST_GRAD: begin
          if (dx[DATA_W] || dx == '0) begin
            lf <= 1'b1;
            g <= '0;
            state <= ST_LIM;
          end else begin
            num <= NUM_W'(dv_mag) << FRAC_BITS;
            den <= DEN_W'(dx);
            neg <= dv[DATA_W];
            mode <= MODE_GRAD;
            state <= ST_PRE;
          end
        end
        ST_PRE: begin
          q <= '0;
          numlo <= num[QBITS-1:0];
          r <= num[NUM_W-1:QBITS];
          cnt <= CNT_W'(QBITS-1);
          ovf <= (num[NUM_W-1:QBITS] >= den);
          state <= (num[NUM_W-1:QBITS] >= den) ? ST_END : ST_DIV;
        end
        ST_DIV: begin
          numlo <= numlo << 1;
          if (r2 >= {1'b0, den}) begin
            r <= DEN_W'(r2 - {1'b0, den});
            q <= {q[QBITS-2:0], 1'b1};
          end else begin
            r <= r2[DEN_W-1:0];
            q <= {q[QBITS-2:0], 1'b0};
          end
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) state <= ST_END;
        end
        ST_END: begin
          if (mode == MODE_GRAD) begin
            g <= sat_res;
            state <= ST_LIM;
          end else begin
            res <= sat_res;
            state <= ST_EMIT1;
          end
        end
        ST_LIM: begin
          if (held_left_gradient == '0 || g == '0 || sum == '0) begin
            res <= '0;
            state <= ST_EMIT1;
          end else begin
            neg <= held_left_gradient[DATA_W-1] ^ g[DATA_W-1] ^ sum[DATA_W];
            mode <= MODE_LIMIT;
            state <= ST_M1;
          end
        end
        ST_M1: begin den <= prod[DEN_W-1:0];        state <= ST_M2; end
        ST_M2: begin den <= den + prod[DEN_W-1:0];  state <= ST_M3; end
        ST_M3: begin ab <= prod[DEN_W-1:0];         state <= ST_M4; end
        ST_M4: begin num <= NUM_W'(prod);           state <= ST_M5; end
        ST_M5: begin
          num <= num + (NUM_W'(prod) << 32);
          state <= ST_PRE;
        end
        ST_EMIT1: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= res;
            m_tuser <= held_fault | lf;
            m_tlast <= 1'b0;
            if (in_fin) state <= ST_EMIT2;
            else begin
              held_value <= in_v;
              held_position <= in_x;
              held_left_gradient <= g;
              held_fault <= lf;
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT2: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= '0;
            m_tuser <= lf;
            m_tlast <= 1'b1;
            held_value <= '0;
            held_position <= '0;
            held_left_gradient <= '0;
            held_fault <= 1'b0;
            sample_pending <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

>>> sv/vags_checker.sv
// Port-level checks for van_albada_gradient_stream_core, bound to the top.
// Depends on nothing but the top level's ports.
module vags_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready) else $error("ready after final request");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == 32'd0) else $error("final slope not zero");
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid) else $error("valid after reset");
endmodule

bind van_albada_gradient_stream_core vags_checker u_vags_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

>>> bench/tb.sv
// Testbench for van_albada_gradient_stream_core: streams runs of samples with random gaps
// and output stalls and checks each slope against a built-in predictor.
// Depends on vags_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vags_pkg::*;

  typedef struct {
    logic [31:0] slope;
    logic        fault;
    logic        last;
  } slope_t;

  class slope_board;
    slope_t      pending_q[$];
    int          errors;
    logic [31:0] prev_v, prev_x, prev_gl;
    logic        prev_fault, have_prev;

    function new();
      errors = 0;
      have_prev = 0;
      prev_v = '0; prev_x = '0; prev_gl = '0; prev_fault = 0;
    endfunction

    static function logic [31:0] sat(longint s);
      if (s > 64'sd2147483647) return 32'h7fffffff;
      if (s < -64'sd2147483648) return 32'h80000000;
      return s[31:0];
    endfunction

    static function logic [31:0] grad(logic [31:0] v0, x0, v1, x1, output logic flt);
      longint dv, dx;
      dv = longint'($signed(v1)) - longint'($signed(v0));
      dx = longint'($signed(x1)) - longint'($signed(x0));
      flt = (dx <= 0);
      if (flt) return '0;
      return sat((dv * 65536) / dx);
    endfunction

    static function logic [31:0] van_albada(logic [31:0] a, b);
      longint sa, sb, ss;
      logic [127:0] ua, ub, us, num, den, q;
      logic neg;
      sa = $signed(a); sb = $signed(b); ss = sa + sb;
      ua = sa < 0 ? -sa : sa;
      ub = sb < 0 ? -sb : sb;
      us = ss < 0 ? -ss : ss;
      if (ua == 0 || ub == 0 || us == 0) return '0;
      num = ua * ub * us;
      den = ua * ua + ub * ub;
      q = num / den;
      neg = ((sa < 0) != (sb < 0)) != (ss < 0);
      if (neg) return q > 128'h80000000 ? 32'h80000000 : 32'(-q);
      return q > 128'h7fffffff ? 32'h7fffffff : q[31:0];
    endfunction

    function void note(logic [31:0] v, x, logic fin);
      logic [31:0] gl;
      logic lf;
      gl = '0; lf = 0;
      if (have_prev) begin
        gl = grad(prev_v, prev_x, v, x, lf);
        pending_q.push_back('{van_albada(prev_gl, gl), prev_fault | lf, 1'b0});
      end
      if (fin) begin
        pending_q.push_back('{32'h0, lf, 1'b1});
        have_prev = 0; prev_v = '0; prev_x = '0; prev_gl = '0; prev_fault = 0;
      end else begin
        prev_v = v; prev_x = x; prev_gl = gl; prev_fault = lf; have_prev = 1;
      end
    endfunction

    function void check(logic [31:0] slope, logic fault, logic last);
      slope_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result slope=%h fault=%b last=%b", slope, fault, last);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (slope !== e.slope) begin
        $error("slope expected %h actual %h", e.slope, slope); errors++;
      end
      if (fault !== e.fault) begin
        $error("step_fault expected %b actual %b", e.fault, fault); errors++;
      end
      if (last !== e.last) begin
        $error("run_end expected %b actual %b", e.last, last); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, s_tlast;
  logic [63:0] s_tdata;
  logic m_tvalid, m_tready, m_tuser, m_tlast;
  logic [31:0] m_tdata;
  logic no_gaps;
  slope_board sb;

  van_albada_gradient_stream_core DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check(m_tdata, m_tuser, m_tlast);

  task automatic send(logic [31:0] v, x, logic fin);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {x, v};
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    sb.note(v, x, fin);
  endtask

  task automatic sink();
    int w;
    forever begin
      w = no_gaps ? 0 : $urandom_range(0, 19);
      if (w > 0) begin
        m_tready <= 0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
    end
  endtask

  task automatic random_run(int n);
    logic [31:0] x, v;
    int mode;
    x = $urandom;
    v = $urandom;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: x = $urandom;
        1: x = x - $urandom_range(0, 3);
        2: x = x + $urandom_range(1, 4);
        default: x = x + (mode == 0 ? $urandom_range(1, 32'h7fff) : $urandom_range(1, 32'h3ffff));
      endcase
      case (mode)
        0: v = $urandom;
        1: v = v + $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
        2: v = $urandom_range(0, 7) == 0 ? v : v + $urandom_range(0, 32'hfff) - 32'h7ff;
        default: v = $urandom_range(0, 3) == 0 ? $urandom : v + $urandom_range(0, 32'hffff);
      endcase
      send(v, x, i == n - 1);
    end
  endtask

  initial begin
    int cnt;
    sb = new();
    rst = 1; s_tvalid = 0; s_tdata = '0; s_tlast = 0; m_tready = 0; no_gaps = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    fork sink(); join_none
    // single-sample run
    send(32'h7fffffff, 32'h80000000, 1);
    // two samples, then flat run
    send(32'h80000000, 32'h80000000, 0);
    send(32'h7fffffff, 32'h80000001, 1);
    send(32'h00010000, 32'h0, 0);
    send(32'h00010000, 32'h00010000, 0);
    send(32'h00010000, 32'h00020000, 1);
    // equal and backward positions
    send(32'h0, 32'h00010000, 0);
    send(32'h00050000, 32'h00010000, 0);
    send(32'h00020000, 32'h0, 0);
    send(32'hffff0000, 32'h7fffffff, 1);
    // opposite signs, extremes, saturating gradients
    send(32'h0, 32'h0, 0);
    send(32'h00030000, 32'h00010000, 0);
    send(32'hfffe0000, 32'h00020000, 0);
    send(32'h7fffffff, 32'h00020001, 0);
    send(32'h80000000, 32'h00020002, 0);
    send(32'h80000000, 32'h7fffffff, 0);
    send(32'h7fffffff, 32'h80000000, 1);
    // gl + gr == 0 and equal gradients
    send(32'h0, 32'h0, 0);
    send(32'h00010000, 32'h00010000, 0);
    send(32'h0, 32'h00020000, 0);
    send(32'h00010000, 32'h00030000, 0);
    send(32'h00020000, 32'h00040000, 1);
    cnt = 0;
    while (cnt < 1250) begin
      int n;
      no_gaps = ((cnt / 150) % 4 == 3);
      n = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 12);
      random_run(n);
      cnt += n;
    end
    s_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
